>>> src/mre_pkg.sv
// Package for the multiset rank encoder: sizes, defaults, job record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mre_pkg;
    localparam int MAX_COUNT_DEF  = 10;
    localparam int RANK_LIMBS_DEF = 5;
    localparam int LIMB_W         = 32;
    localparam int VALUE_W        = 16;
    localparam int LEN_W          = 4;
    localparam int IDX_W          = 3;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int N_W            = 17;

    localparam logic [VALUE_W-1:0]   EMPTY_MARK      = 16'hFFFF;
    localparam logic [LEN_W-1:0]     LIST_LENGTH_RST = 4'd10;
    localparam logic [VALUE_W-1:0]   EMPTY_CODE_RST  = 16'd60000;
    localparam logic [CFG_IDX_W-1:0] REG_LIST_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CODE  = 2'd1;

    typedef struct packed {
        logic [N_W-1:0]   n;
        logic [LEN_W-1:0] k;
        logic             acc_en;
        logic             last;
        logic             bad;
    } mre_job_t;
endpackage
`default_nettype wire

>>> src/mre_if.sv
// Channel interfaces for the multiset rank encoder.
// Depends on mre_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface mre_value_if;
    import mre_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface mre_rank_if;
    import mre_pkg::*;
    logic              valid;
    logic              ready;
    logic [LIMB_W-1:0] rank_limb;
    logic [IDX_W-1:0]  limb_index;
    logic              list_valid;
    logic              last;
    modport source (output valid, output rank_limb, output limb_index, output list_valid,
                    output last, input ready);
    modport sink (input valid, input rank_limb, input limb_index, input list_valid,
                  input last, output ready);
endinterface

interface mre_cfg_if;
    import mre_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> src/multiset_rank_encoder_core.sv
// Multiset rank encoder. Per element at position i (value non-zero, no error):
// (i+1) multiply-and-divide passes over the limbs (one limb multiply a cycle, 8 divide
// bits a cycle), then an add pass over the limbs and a return to idle.
// Zero or erroneous elements skip the passes. Last element: then RANK_LIMBS output beats.
// Two-entry queue buffers items. Reset clears all but queue data; registers to defaults.
`timescale 1ns / 1ps
`default_nettype none
module multiset_rank_encoder_core
    import mre_pkg::*;
#(
    parameter int MAX_COUNT  = MAX_COUNT_DEF,
    parameter int RANK_LIMBS = RANK_LIMBS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mre_cfg_if.sink    cfg,
    mre_value_if.sink  items,
    mre_rank_if.source ranks
);
    mre_job_t f_job;
    logic     f_valid;
    logic     f_ready;
    mre_job_t q_job;
    logic     q_valid;
    logic     q_ready;

    mre_front #(.MAX_COUNT(MAX_COUNT)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .cfg       (cfg),
        .job       (f_job),
        .job_valid (f_valid),
        .job_ready (f_ready)
    );

    mre_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_job    (f_job),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .out_job   (q_job),
        .out_valid (q_valid),
        .out_ready (q_ready)
    );

    mre_back #(.RANK_LIMBS(RANK_LIMBS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (q_job),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .ranks     (ranks)
    );
endmodule
`default_nettype wire

>>> src/mre_front.sv
// Front end: config registers, per-list tracking, element checks, job build.
// Depends on mre_pkg and mre_if.
`timescale 1ns / 1ps
`default_nettype none
module mre_front
    import mre_pkg::*;
#(
    parameter int MAX_COUNT = MAX_COUNT_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mre_value_if.sink items,
    mre_cfg_if.sink   cfg,
    output mre_job_t  job,
    output logic      job_valid,
    input  wire logic job_ready
);
    localparam logic [LEN_W:0] MAX_LEN = (LEN_W+1)'(MAX_COUNT);

    logic [LEN_W-1:0]   list_length_reg;
    logic [VALUE_W-1:0] empty_code_reg;
    logic [LEN_W-1:0]   position_reg;
    logic [VALUE_W-1:0] prev_reg;
    logic               err_reg;

    logic [LEN_W:0]     len_eff;
    logic [VALUE_W-1:0] v;
    logic               new_err;
    logic               is_last;
    logic               accept;

    assign cfg.ready   = 1'b1;
    assign items.ready = job_ready;
    assign job_valid   = items.valid;
    assign accept      = items.valid && job_ready;

    always_comb
    begin
        len_eff = {1'b0, list_length_reg};
        if (len_eff == '0)
            len_eff = (LEN_W+1)'(1);
        if (len_eff > MAX_LEN)
            len_eff = MAX_LEN;
        v       = (items.value == EMPTY_MARK) ? empty_code_reg : items.value;
        new_err = (v > empty_code_reg)
               || (v == empty_code_reg && items.value != EMPTY_MARK)
               || (v < prev_reg);
        is_last = ({1'b0, position_reg} + (LEN_W+1)'(1)) >= len_eff;
        job.n      = {1'b0, v} + N_W'(position_reg);
        job.k      = position_reg + LEN_W'(1);
        job.acc_en = !err_reg && !new_err && (v != '0);
        job.last   = is_last;
        job.bad    = err_reg || new_err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_length_reg <= LIST_LENGTH_RST;
            empty_code_reg  <= EMPTY_CODE_RST;
            position_reg    <= '0;
            prev_reg        <= '0;
            err_reg         <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_LIST_LENGTH: list_length_reg <= cfg.data[LEN_W-1:0];
                    REG_EMPTY_CODE:  empty_code_reg  <= cfg.data[VALUE_W-1:0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                if (is_last)
                begin
                    position_reg <= '0;
                    prev_reg     <= '0;
                    err_reg      <= 1'b0;
                end
                else
                begin
                    position_reg <= position_reg + LEN_W'(1);
                    if (!err_reg && !new_err)
                        prev_reg <= v;
                    if (new_err)
                        err_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> src/mre_queue.sv
// Two-entry job queue between front and back.
// Depends on mre_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mre_queue
    import mre_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mre_job_t in_job,
    input  wire logic     in_valid,
    output logic          in_ready,
    output mre_job_t      out_job,
    output logic          out_valid,
    input  wire logic     out_ready
);
    mre_job_t   mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_job   = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= in_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

>>> src/mre_back.sv
// Back end: binomial by multiply and exact-divide passes, rank accumulate, limb output.
// Depends on mre_pkg and mre_if.
`timescale 1ns / 1ps
`default_nettype none
module mre_back
    import mre_pkg::*;
#(
    parameter int RANK_LIMBS = RANK_LIMBS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mre_job_t job,
    input  wire logic     job_valid,
    output logic          job_ready,
    mre_rank_if.source    ranks
);
    localparam int W      = LIMB_W * RANK_LIMBS;
    localparam int DIV_CY = W / 8;
    localparam int LC_W   = $clog2(RANK_LIMBS);
    localparam int DC_W   = $clog2(DIV_CY);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_ADD, S_EMIT} state_t;

    state_t              state_reg;
    logic [W-1:0]        b_reg;
    logic [W-1:0]        acc_reg;
    logic [N_W-1:0]      n_reg;
    logic [LEN_W-1:0]    k_reg;
    logic [LEN_W-1:0]    j_reg;
    logic                last_reg;
    logic                bad_reg;
    logic [LC_W-1:0]     limb_reg;
    logic [DC_W-1:0]     dcnt_reg;
    logic [N_W-1:0]      carry_reg;
    logic [LEN_W-1:0]    rem_reg;
    logic [IDX_W-1:0]    out_idx_reg;

    logic [N_W-1:0]      mul;
    logic [LIMB_W+N_W:0] prod;
    logic [W-1:0]        div_b;
    logic [LEN_W:0]      div_r;
    logic [LIMB_W:0]     add_sum;
    logic                limb_end;

    assign job_ready        = (state_reg == S_IDLE);
    assign ranks.valid      = (state_reg == S_EMIT);
    assign ranks.rank_limb  = bad_reg ? '0 : acc_reg[LIMB_W-1:0];
    assign ranks.limb_index = out_idx_reg;
    assign ranks.list_valid = !bad_reg;
    assign ranks.last       = (out_idx_reg == IDX_W'(RANK_LIMBS - 1));
    assign limb_end         = (limb_reg == LC_W'(RANK_LIMBS - 1));

    always_comb
    begin
        mul     = n_reg - N_W'(j_reg) + N_W'(1);
        prod    = (LIMB_W+N_W+1)'(b_reg[LIMB_W-1:0]) * (LIMB_W+N_W+1)'(mul)
                + (LIMB_W+N_W+1)'(carry_reg);
        add_sum = (LIMB_W+1)'(acc_reg[LIMB_W-1:0]) + (LIMB_W+1)'(b_reg[LIMB_W-1:0])
                + (LIMB_W+1)'(carry_reg[0]);
        div_b   = b_reg;
        div_r   = {1'b0, rem_reg};
        for (int s = 0; s < 8; s++)
        begin
            div_r = {div_r[LEN_W-1:0], div_b[W-1]};
            div_b = {div_b[W-2:0], 1'b0};
            if (div_r >= {1'b0, j_reg})
            begin
                div_r    = div_r - {1'b0, j_reg};
                div_b[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            acc_reg     <= '0;
            b_reg       <= '0;
            n_reg       <= '0;
            k_reg       <= '0;
            j_reg       <= '0;
            last_reg    <= 1'b0;
            bad_reg     <= 1'b0;
            limb_reg    <= '0;
            dcnt_reg    <= '0;
            carry_reg   <= '0;
            rem_reg     <= '0;
            out_idx_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        n_reg     <= job.n;
                        k_reg     <= job.k;
                        j_reg     <= LEN_W'(1);
                        last_reg  <= job.last;
                        bad_reg   <= job.bad;
                        b_reg     <= W'(1);
                        limb_reg  <= '0;
                        carry_reg <= '0;
                        if (job.acc_en)
                            state_reg <= S_MUL;
                        else if (job.last)
                        begin
                            out_idx_reg <= '0;
                            state_reg   <= S_EMIT;
                        end
                    end
                end
                S_MUL:
                begin
                    b_reg     <= {prod[LIMB_W-1:0], b_reg[W-1:LIMB_W]};
                    carry_reg <= prod[LIMB_W+N_W-1:LIMB_W];
                    limb_reg  <= limb_reg + LC_W'(1);
                    if (limb_end)
                    begin
                        limb_reg  <= '0;
                        dcnt_reg  <= '0;
                        rem_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    b_reg    <= div_b;
                    rem_reg  <= div_r[LEN_W-1:0];
                    dcnt_reg <= dcnt_reg + DC_W'(1);
                    if (dcnt_reg == DC_W'(DIV_CY - 1))
                    begin
                        carry_reg <= '0;
                        if (j_reg == k_reg)
                            state_reg <= S_ADD;
                        else
                        begin
                            j_reg     <= j_reg + LEN_W'(1);
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_ADD:
                begin
                    acc_reg   <= {add_sum[LIMB_W-1:0], acc_reg[W-1:LIMB_W]};
                    b_reg     <= {LIMB_W'(0), b_reg[W-1:LIMB_W]};
                    carry_reg <= N_W'(add_sum[LIMB_W]);
                    limb_reg  <= limb_reg + LC_W'(1);
                    if (limb_end)
                    begin
                        limb_reg <= '0;
                        if (last_reg)
                        begin
                            out_idx_reg <= '0;
                            state_reg   <= S_EMIT;
                        end
                        else
                            state_reg <= S_IDLE;
                    end
                end
                S_EMIT:
                begin
                    if (ranks.ready)
                    begin
                        acc_reg     <= {LIMB_W'(0), acc_reg[W-1:LIMB_W]};
                        out_idx_reg <= out_idx_reg + IDX_W'(1);
                        if (ranks.last)
                            state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> test/tb_multiset_rank_encoder_core.sv
// Testbench for multiset_rank_encoder_core: directed table then random lists,
// every rank beat checked against an in-bench rank predictor. Needs mre_pkg, mre_if.
`timescale 1ns / 1ps
module tb_multiset_rank_encoder_core;
    import mre_pkg::*;

    typedef struct packed {
        logic [LIMB_W-1:0] limb;
        logic [IDX_W-1:0]  idx;
        logic              ok;
        logic              last;
    } rank_beat_t;

    typedef struct {
        logic [VALUE_W-1:0] value;
        bit                 typed;
        rank_beat_t         want;
    } stim_row_t;

    localparam int WATCHDOG = 20000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    bit   failed;
    int   idle_cycles;
    bit   items_on;

    mre_cfg_if   cfg();
    mre_value_if items();
    mre_rank_if  ranks();

    multiset_rank_encoder_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg.sink),
        .items (items.sink),
        .ranks (ranks.source)
    );

    // predictor state
    logic [LEN_W-1:0]   len_reg;
    logic [VALUE_W-1:0] empty_reg;
    logic [159:0]       rank_sum;
    int unsigned        pos;
    logic [VALUE_W-1:0] prev_val;
    bit                 list_bad;
    rank_beat_t         pending_ranks[$];
    // typed expectations of the directed table, paired with predictor output
    rank_beat_t         typed_ranks[$];
    bit                 typed_flags[$];

    stim_row_t table_rows[$];

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [159:0] binomial(int unsigned n, int unsigned k);
        logic [191:0] acc;
        acc = 1;
        if (n < k)
            return '0;
        for (int unsigned j = 1; j <= k; j++)
        begin
            acc = acc[159:0] * (n - j + 1);
            acc = acc[159:0] / j;
        end
        return acc[159:0];
    endfunction

    task automatic predict_rank(input logic [VALUE_W-1:0] raw, input bit typed,
                                input rank_beat_t want);
        int unsigned eff_len;
        int unsigned v;
        rank_beat_t  b;
        eff_len = (len_reg < 1) ? 1 : (len_reg > 10 ? 10 : len_reg);
        v = (raw == EMPTY_MARK) ? empty_reg : raw;
        if (!list_bad)
        begin
            if (v > empty_reg || (v == empty_reg && raw != EMPTY_MARK) || v < prev_val)
                list_bad = 1;
            else
            begin
                rank_sum = rank_sum + binomial(v + pos, pos + 1);
                prev_val = VALUE_W'(v);
            end
        end
        if (pos + 1 < eff_len)
        begin
            pos = (pos + 1) & 4'hF;
            return;
        end
        for (int k = 0; k < 5; k++)
        begin
            b.limb = list_bad ? '0 : rank_sum[k*32 +: 32];
            b.idx  = IDX_W'(k);
            b.ok   = !list_bad;
            b.last = (k == 4);
            pending_ranks.push_back(b);
            typed_flags.push_back(typed && k == 0);
            typed_ranks.push_back(want);
        end
        rank_sum = '0;
        pos      = 0;
        prev_val = '0;
        list_bad = 0;
    endtask

    // result side
    initial
    begin
        rank_beat_t got;
        rank_beat_t exp_b;
        rank_beat_t typed_b;
        bit         tf;
        int         wait_n;
        ranks.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (wait_n != 0)
            begin
                ranks.ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            ranks.ready <= 1'b1;
            do
                @(posedge clk);
            while (!ranks.valid);
            got = '{ranks.rank_limb, ranks.limb_index, ranks.list_valid, ranks.last};
            if (pending_ranks.size() == 0)
            begin
                $display("%0t unexpected rank beat: expected none, actual %p", $time, got);
                failed = 1;
            end
            else
            begin
                exp_b   = pending_ranks.pop_front();
                typed_b = typed_ranks.pop_front();
                tf      = typed_flags.pop_front();
                if (tf && typed_b != exp_b)
                begin
                    $display("%0t table/predictor disagree: expected %p, actual %p",
                             $time, typed_b, exp_b);
                    failed = 1;
                end
                if (got.limb !== exp_b.limb)
                begin
                    $display("%0t rank_limb: expected %h, actual %h", $time, exp_b.limb, got.limb);
                    failed = 1;
                end
                if (got.idx !== exp_b.idx)
                begin
                    $display("%0t limb_index: expected %0d, actual %0d", $time, exp_b.idx,
                             got.idx);
                    failed = 1;
                end
                if (got.ok !== exp_b.ok)
                begin
                    $display("%0t list_valid: expected %b, actual %b", $time, exp_b.ok, got.ok);
                    failed = 1;
                end
                if (got.last !== exp_b.last)
                begin
                    $display("%0t last: expected %b, actual %b", $time, exp_b.last, got.last);
                    failed = 1;
                end
            end
        end
    end

    // watchdog on accepted beats
    always @(posedge clk)
    begin
        if ((items.valid && items.ready) || (ranks.valid && ranks.ready) ||
            (cfg.valid && cfg.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic idle_items;
        if (items_on)
        begin
            items.valid <= 1'b0;
            items_on = 0;
        end
    endtask

    task automatic send_value(input logic [VALUE_W-1:0] raw, input bit typed,
                              input rank_beat_t want);
        int wait_n;
        wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        if (wait_n != 0)
        begin
            idle_items();
            repeat (wait_n) @(posedge clk);
        end
        items.valid <= 1'b1;
        items.value <= raw;
        items_on = 1;
        do
            @(posedge clk);
        while (!items.ready);
        predict_rank(raw, typed, want);
    endtask

    task automatic drain;
        idle_items();
        while (pending_ranks.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == REG_LIST_LENGTH)
            len_reg = data[LEN_W-1:0];
        else if (idx == REG_EMPTY_CODE)
            empty_reg = data;
        @(posedge clk);
    endtask

    task automatic add_row(input logic [VALUE_W-1:0] v, input bit typed,
                           input rank_beat_t want);
        stim_row_t r;
        r.value = v;
        r.typed = typed;
        r.want  = want;
        table_rows.push_back(r);
    endtask

    task automatic random_list(input int unsigned n);
        logic [VALUE_W-1:0] v;
        int unsigned        mode;
        v = '0;
        mode = $urandom_range(0, 9);
        for (int unsigned i = 0; i < n; i++)
        begin
            if (mode < 7)
            begin
                // well-formed: non-decreasing, below empty_code, maybe an empty mark last
                v = VALUE_W'($urandom_range(v, empty_reg - 1));
                if ($urandom_range(0, 1) && (32'(v) + 3 < 32'(empty_reg)))
                    v = v + VALUE_W'($urandom_range(0, 3));
                if (i == n - 1 && $urandom_range(0, 3) == 0)
                    v = EMPTY_MARK;
            end
            else if (mode == 7)
                v = VALUE_W'($urandom);
            else if (mode == 8)
                v = (i == n / 2) ? empty_reg : VALUE_W'($urandom_range(0, empty_reg));
            else
                v = (i == 0) ? empty_reg - 16'd1 : VALUE_W'($urandom_range(0, 3));
            send_value(v, 0, '0);
        end
    endtask

    initial
    begin
        int sent;
        int next_cfg;
        int unsigned eff;
        rst_n       <= 1'b0;
        items.valid <= 1'b0;
        items.value <= '0;
        cfg.valid   <= 1'b0;
        cfg.index   <= '0;
        cfg.data    <= '0;
        failed      = 0;
        items_on    = 0;
        len_reg     = LIST_LENGTH_RST;
        empty_reg   = EMPTY_CODE_RST;
        rank_sum    = '0;
        pos         = 0;
        prev_val    = '0;
        list_bad    = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single-element lists first, default empty code
        write_reg(REG_LIST_LENGTH, 16'd1);
        add_row(16'd0, 1, '{32'd0, 3'd0, 1'b1, 1'b0});
        add_row(16'd59999, 1, '{32'd59999, 3'd0, 1'b1, 1'b0});
        add_row(16'd60000, 1, '{32'd0, 3'd0, 1'b0, 1'b0});
        add_row(EMPTY_MARK, 1, '{32'd60000, 3'd0, 1'b1, 1'b0});
        add_row(16'd60001, 1, '{32'd0, 3'd0, 1'b0, 1'b0});
        add_row(16'hAAAA, 1, '{32'd43690, 3'd0, 1'b1, 1'b0});
        add_row(16'h5555, 1, '{32'd21845, 3'd0, 1'b1, 1'b0});
        foreach (table_rows[i])
            send_value(table_rows[i].value, table_rows[i].typed, table_rows[i].want);
        table_rows.delete();
        drain();

        // full-length lists at defaults: maximum, decreasing, empties
        write_reg(REG_LIST_LENGTH, 16'd10);
        for (int i = 0; i < 10; i++)
            add_row(16'd59999, 0, '0);
        for (int i = 0; i < 10; i++)
            add_row(i == 3 ? 16'd5 : 16'd7, 0, '0);
        for (int i = 0; i < 10; i++)
            add_row(i < 2 ? 16'd0 : EMPTY_MARK, 0, '0);
        foreach (table_rows[i])
            send_value(table_rows[i].value, 0, '0);
        table_rows.delete();
        drain();

        // out-of-range lengths, small and large empty codes
        write_reg(REG_LIST_LENGTH, 16'd0);
        write_reg(REG_EMPTY_CODE, 16'd1);
        send_value(16'd0, 0, '0);
        send_value(EMPTY_MARK, 0, '0);
        send_value(16'd1, 0, '0);
        drain();
        write_reg(REG_LIST_LENGTH, 16'd15);
        write_reg(REG_EMPTY_CODE, 16'd65534);
        for (int i = 0; i < 10; i++)
            send_value(i < 9 ? 16'd65533 : EMPTY_MARK, 0, '0);
        drain();

        // random phases with a fresh setting each time
        sent = 0;
        next_cfg = 0;
        while (sent < 500)
        begin
            if (sent >= next_cfg)
            begin
                next_cfg += 100;
                drain();
                write_reg(REG_LIST_LENGTH, CFG_DATA_W'($urandom_range(0, 15)));
                write_reg(REG_EMPTY_CODE, ($urandom_range(0, 1))
                                          ? CFG_DATA_W'($urandom_range(1, 65534))
                                          : CFG_DATA_W'($urandom_range(1, 300)));
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
            end
            eff = (len_reg < 1) ? 1 : (len_reg > 10 ? 10 : len_reg);
            // one random list of the current effective length
            random_list(eff);
            sent += eff;
            if (sent % 50 < eff)
            begin
                idle_items();
                while (pending_ranks.size() != 0)
                    @(posedge clk);
            end
        end

        idle_items();
        while (pending_ranks.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (!failed)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
